// ----- rtl/core/enbp_pkg.sv -----
// Shared types and constants for the elastic-net ball projection block.
// No dependencies; imported by the top level and the checker of the block.
package enbp_pkg;

  localparam int MAX_LEN_DEF = 64;

  localparam int ELEM_W    = 24;  // signed Q8.16 element
  localparam int MAG_W     = 23;  // kept magnitude and theta, Q7.16
  localparam int SUM_W     = 48;  // penalty sum, Q.16
  localparam int RAD_W     = 32;  // radius, Q16.16
  localparam int RIDGE_W   = 20;  // gamma, Q4.16
  localparam int PASS_W    = 7;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  localparam int WIDE_W  = 92;    // discriminant and shared subtractor width
  localparam int B_W     = 38;
  localparam int A_W     = 41;
  localparam int BB_W    = 76;
  localparam int DEN_W   = 48;
  localparam int ROOT_W  = 46;
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 23;
  localparam int MUL_P_W = 53;
  localparam int PEN_W   = 34;
  localparam int CNT_W   = 6;
  localparam int QO_W    = 24;

  localparam logic [CNT_W-1:0] SQ_LAST_BIT  = CNT_W'(45);
  localparam logic [CNT_W-1:0] TH_LAST_BIT  = CNT_W'(22);
  localparam logic [CNT_W-1:0] OUT_LAST_BIT = CNT_W'(23);

  localparam logic [MAG_W-1:0] THETA_MAX = {MAG_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RIDGE  = CFG_IDX_W'(1);

  localparam logic [RAD_W-1:0]   RADIUS_RST = RAD_W'(65536);
  localparam logic [RIDGE_W-1:0] RIDGE_RST  = '0;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_P_RD,
    ST_P_MUL1,
    ST_P_MUL2,
    ST_P_ACC,
    ST_CHECK,
    ST_SV_START,
    ST_SV_MUL,
    ST_SV_SQRT,
    ST_SV_DVCHK,
    ST_SV_DIV,
    ST_E_DEN1,
    ST_E_DEN2,
    ST_E_RD,
    ST_E_GET,
    ST_E_DIV
  } state_t;

  typedef enum logic [1:0] {
    MS_RG,  // radius * gamma
    MS_BG,  // b * gamma
    MS_BB,  // b * b
    MS_AD   // a * d
  } mstep_t;

endpackage

// ----- rtl/core/enbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the element and magnitude stores.
module enbp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/elastic_net_ball_projection_top.sv -----
// Top level of the elastic-net ball projection block.
// Depends on enbp_pkg and enbp_ram.

// Projects a vector of up to MAX_LEN signed Q8.16 words onto the ball
// ||x||_1 + gamma/2*||x||_2^2 <= radius. Words are taken one per cycle while
// busy is low (start high); the word with in_last_in set closes the vector and
// busy rises. The block first sums the penalty over the vector (read,
// multiply and accumulate states per word, one shared 30x23 multiplier). If
// the vector is outside the ball, each refinement pass solves for theta with a
// bit-serial multiplier (one bit of the multiplier operand per cycle, four
// products), a 46-step square root and a 23-step divide on one shared 92-bit
// subtractor, then re-scans the kept magnitudes. Results then leave word by
// word; after a pass, a word above theta goes through a 24-step divide by
// 1+gamma*theta and a word at or below theta is sent as zero. Each result is
// shown for exactly one cycle on out_strobe; the receiver cannot stall, so it
// must take every word as it appears. Configuration may be written only while
// busy is low and no vector is partly loaded.
module elastic_net_ball_projection_top import enbp_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [ELEM_W-1:0]   in_element,
  input  logic                       in_last_in,
  output logic                       out_strobe,
  output logic signed [ELEM_W-1:0]   out_projected,
  output logic [MAG_W-1:0]           out_threshold,
  output logic [PASS_W-1:0]          out_passes,
  output logic                       out_last_out,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  // ---------------- registers ----------------
  state_t              state_r, state_nxt;
  mstep_t              mstep_r, mstep_nxt;
  logic [CW-1:0]       loaded_r, loaded_nxt;    // words stored so far
  logic [CW-1:0]       n_r, n_nxt;              // vector length
  logic [CW-1:0]       idx_r, idx_nxt;          // scan index
  logic [CW-1:0]       wr_r, wr_nxt;            // compaction write index
  logic [CW-1:0]       before_r, before_nxt;    // kept count at scan start
  logic [CW-1:0]       k_r, k_nxt;              // kept count
  logic [CW-1:0]       pass_r, pass_nxt;
  logic                init_r, init_nxt;        // first scan: no pass yet
  logic [MAG_W-1:0]    theta_r, theta_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [RAD_W-1:0]    radius_r, radius_nxt;
  logic [RIDGE_W-1:0]  ridge_r, ridge_nxt;
  logic [MAG_W-1:0]    m_r, m_nxt;
  logic                keep_r, keep_nxt;
  logic [MUL_P_W-1:0]  mul_r;
  logic [B_W-1:0]      b_r, b_nxt;
  logic [A_W-1:0]      a_r, a_nxt;
  logic [SUM_W-1:0]    d_r, d_nxt;
  logic [BB_W-1:0]     disc_r, disc_nxt;
  logic [WIDE_W-1:0]   acc_r, acc_nxt;          // product / radicand / remainder
  logic [WIDE_W-1:0]   x_r, x_nxt;              // multiplicand / root
  logic [DEN_W-1:0]    y_r, y_nxt;              // multiplier bits / output divisor
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [QO_W-1:0]     qo_r, qo_nxt;
  logic                neg_r, neg_nxt;

  logic                      strobe_r, strobe_nxt;
  logic signed [ELEM_W-1:0]  proj_r, proj_nxt;
  logic                      last_r, last_nxt;

  // ---------------- memories ----------------
  logic                kept_we, orig_we;
  logic [AW-1:0]       kept_waddr, orig_waddr, rd_addr;
  logic [MAG_W-1:0]    kept_wdata, kept_q;
  logic [ELEM_W-1:0]   orig_q;

  assign rd_addr    = idx_r[AW-1:0];
  assign orig_waddr = loaded_r[AW-1:0];

  enbp_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LEN)) u_orig (
    .clk   (clk),
    .we    (orig_we),
    .waddr (orig_waddr),
    .wdata (in_element),
    .raddr (rd_addr),
    .rdata (orig_q)
  );

  enbp_ram #(.WIDTH(MAG_W), .DEPTH(MAX_LEN)) u_kept (
    .clk   (clk),
    .we    (kept_we),
    .waddr (kept_waddr),
    .wdata (kept_wdata),
    .raddr (rd_addr),
    .rdata (kept_q)
  );

  // ---------------- shared units ----------------
  // Per-word multiplier: m*m, square*gamma, gamma*theta.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // Wide subtractor: sqrt trial, theta divide, output divide.
  logic [WIDE_W-1:0] one_bit;    // 4^cnt for the root
  logic [WIDE_W-1:0] sub_b;
  logic [WIDE_W:0]   diff;
  logic              ge;
  logic [DEN_W-1:0]  den_sv;     // b + root

  assign one_bit = WIDE_W'(1) << {cnt_r, 1'b0};
  assign den_sv  = DEN_W'(b_r) + DEN_W'(x_r[ROOT_W-1:0]);

  always_comb begin
    case (state_r)
      ST_SV_SQRT:  sub_b = x_r + one_bit;
      ST_SV_DVCHK: sub_b = WIDE_W'(den_sv) << 23;
      ST_SV_DIV:   sub_b = WIDE_W'(den_sv) << cnt_r;
      ST_E_DIV:    sub_b = WIDE_W'(y_r) << cnt_r;
      default:     sub_b = '0;
    endcase
  end

  assign diff = {1'b0, acc_r} - {1'b0, sub_b};
  assign ge   = ~diff[WIDE_W];

  // Input magnitude, clamped for the kept store.
  logic [ELEM_W-1:0] in_mag;
  assign in_mag = in_element[ELEM_W-1] ? (~in_element + 1'b1) : in_element;

  logic [CW-1:0] loaded_inc;
  logic          room;
  assign room       = loaded_r < CW'(MAX_LEN);
  assign loaded_inc = room ? loaded_r + 1'b1 : loaded_r;

  logic scan_last, emit_last;
  assign scan_last = (idx_r + 1'b1) == before_r;
  assign emit_last = (idx_r + 1'b1) == n_r;

  logic [ELEM_W-1:0] c_mag;
  assign c_mag = orig_q[ELEM_W-1] ? (~orig_q + 1'b1) : orig_q;

  assign busy = state_r != ST_LOAD;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:     if (start && in_last_in) state_nxt = ST_P_RD;
      ST_P_RD:     state_nxt = ST_P_MUL1;
      ST_P_MUL1:   state_nxt = ST_P_MUL2;
      ST_P_MUL2:   state_nxt = ST_P_ACC;
      ST_P_ACC:    state_nxt = scan_last ? ST_CHECK : ST_P_RD;
      ST_CHECK: begin
        if (init_r) begin
          state_nxt = (sum_r > SUM_W'(radius_r)) ? ST_SV_START : ST_E_DEN1;
        end else if (wr_r == before_r || wr_r == '0) begin
          state_nxt = ST_E_DEN1;
        end else begin
          state_nxt = ST_SV_START;
        end
      end
      ST_SV_START: state_nxt = (sum_r <= SUM_W'(radius_r)) ? ST_P_RD : ST_SV_MUL;
      ST_SV_MUL:   if (y_r == '0 && mstep_r == MS_AD) state_nxt = ST_SV_SQRT;
      ST_SV_SQRT:  if (cnt_r == '0) state_nxt = ST_SV_DVCHK;
      ST_SV_DVCHK: state_nxt = ge ? ST_P_RD : ST_SV_DIV;
      ST_SV_DIV:   if (cnt_r == '0) state_nxt = ST_P_RD;
      ST_E_DEN1:   state_nxt = ST_E_DEN2;
      ST_E_DEN2:   state_nxt = ST_E_RD;
      ST_E_RD:     state_nxt = ST_E_GET;
      ST_E_GET: begin
        if (pass_r != '0 && c_mag > ELEM_W'(theta_r)) begin
          state_nxt = ST_E_DIV;
        end else begin
          state_nxt = emit_last ? ST_LOAD : ST_E_RD;
        end
      end
      ST_E_DIV: begin
        if (cnt_r == '0) state_nxt = emit_last ? ST_LOAD : ST_E_RD;
      end
      default:     state_nxt = ST_LOAD;
    endcase
  end

  // ---------------- datapath ----------------
  always_comb begin
    logic [PEN_W-1:0]  pen;
    logic [SUM_W:0]    s_add;
    logic [B_W-1:0]    b_calc;
    logic [QO_W-1:0]   q_fin;
    logic              pass_init;

    mstep_nxt  = mstep_r;
    loaded_nxt = loaded_r;
    n_nxt      = n_r;
    idx_nxt    = idx_r;
    wr_nxt     = wr_r;
    before_nxt = before_r;
    k_nxt      = k_r;
    pass_nxt   = pass_r;
    init_nxt   = init_r;
    theta_nxt  = theta_r;
    sum_nxt    = sum_r;
    radius_nxt = radius_r;
    ridge_nxt  = ridge_r;
    m_nxt      = m_r;
    keep_nxt   = keep_r;
    b_nxt      = b_r;
    a_nxt      = a_r;
    d_nxt      = d_r;
    disc_nxt   = disc_r;
    acc_nxt    = acc_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    cnt_nxt    = cnt_r;
    qo_nxt     = qo_r;
    neg_nxt    = neg_r;
    strobe_nxt = 1'b0;
    proj_nxt   = proj_r;
    last_nxt   = last_r;

    kept_we    = 1'b0;
    orig_we    = 1'b0;
    kept_waddr = loaded_r[AW-1:0];
    kept_wdata = in_mag[ELEM_W-1] ? THETA_MAX : in_mag[MAG_W-1:0];
    mul_a      = MUL_A_W'(kept_q);
    mul_b      = kept_q;

    pen       = PEN_W'(m_r) + PEN_W'(mul_r[49:17]);
    s_add     = (SUM_W+1)'(sum_r) + (SUM_W+1)'(pen);
    b_calc    = B_W'(acc_r[51:15]) + B_W'({k_r, 16'b0});
    q_fin     = {qo_r[QO_W-2:0], ge};
    pass_init = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS: radius_nxt = cfg_data;
        REG_RIDGE:  ridge_nxt  = cfg_data[RIDGE_W-1:0];
        default:    ;
      endcase
    end

    case (state_r)
      ST_LOAD: begin
        if (start) begin
          orig_we = room;
          kept_we = room;
          if (in_last_in) begin
            loaded_nxt = '0;
            n_nxt      = loaded_inc;
            before_nxt = loaded_inc;
            idx_nxt    = '0;
            wr_nxt     = '0;
            sum_nxt    = '0;
            theta_nxt  = '0;
            pass_nxt   = '0;
            init_nxt   = 1'b1;
          end else begin
            loaded_nxt = loaded_inc;
          end
        end
      end
      ST_P_MUL1: begin
        // square goes to the multiplier, compaction write-back
        m_nxt      = kept_q;
        keep_nxt   = kept_q >= theta_r;
        kept_we    = kept_q >= theta_r;
        kept_waddr = wr_r[AW-1:0];
        kept_wdata = kept_q;
        if (kept_q >= theta_r) wr_nxt = wr_r + 1'b1;
      end
      ST_P_MUL2: begin
        mul_a = mul_r[45:16];
        mul_b = MUL_B_W'(ridge_r);
      end
      ST_P_ACC: begin
        if (keep_r) sum_nxt = s_add[SUM_W] ? SUM_MAX : s_add[SUM_W-1:0];
        idx_nxt = idx_r + 1'b1;
      end
      ST_CHECK: begin
        k_nxt    = wr_r;
        init_nxt = 1'b0;
      end
      ST_SV_START: begin
        pass_nxt = pass_r + 1'b1;
        if (sum_r <= SUM_W'(radius_r)) begin
          theta_nxt = '0;
          pass_init = 1'b1;
        end else begin
          d_nxt     = sum_r - SUM_W'(radius_r);
          x_nxt     = WIDE_W'(radius_r);
          y_nxt     = DEN_W'(ridge_r);
          acc_nxt   = '0;
          mstep_nxt = MS_RG;
        end
      end
      ST_SV_MUL: begin
        if (y_r != '0) begin
          acc_nxt = acc_r + (y_r[0] ? x_r : '0);
          x_nxt   = x_r << 1;
          y_nxt   = y_r >> 1;
        end else begin
          case (mstep_r)
            MS_RG: begin
              b_nxt     = b_calc;
              x_nxt     = WIDE_W'(b_calc);
              y_nxt     = DEN_W'(ridge_r);
              acc_nxt   = '0;
              mstep_nxt = MS_BG;
            end
            MS_BG: begin
              a_nxt     = acc_r[57:17];
              x_nxt     = WIDE_W'(b_r);
              y_nxt     = DEN_W'(b_r);
              acc_nxt   = '0;
              mstep_nxt = MS_BB;
            end
            MS_BB: begin
              disc_nxt  = acc_r[BB_W-1:0];
              x_nxt     = WIDE_W'(a_r);
              y_nxt     = d_r;
              acc_nxt   = '0;
              mstep_nxt = MS_AD;
            end
            MS_AD: begin
              // radicand b^2 + 4ad, root starts at zero
              acc_nxt = WIDE_W'(disc_r) + (acc_r << 2);
              x_nxt   = '0;
              cnt_nxt = SQ_LAST_BIT;
            end
            default: mstep_nxt = MS_RG;
          endcase
        end
      end
      ST_SV_SQRT: begin
        if (ge) begin
          acc_nxt = diff[WIDE_W-1:0];
          x_nxt   = (x_r >> 1) + one_bit;
        end else begin
          x_nxt   = x_r >> 1;
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) acc_nxt = WIDE_W'({d_r, 17'b0});  // 2d in Q.32
      end
      ST_SV_DVCHK: begin
        if (ge) begin
          theta_nxt = THETA_MAX;   // quotient of 128 or more, or zero divisor
          pass_init = 1'b1;
        end else begin
          theta_nxt = '0;
          cnt_nxt   = TH_LAST_BIT;
        end
      end
      ST_SV_DIV: begin
        if (ge) acc_nxt = diff[WIDE_W-1:0];
        theta_nxt = {theta_r[MAG_W-2:0], ge};
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) pass_init = 1'b1;
      end
      ST_E_DEN1: begin
        mul_a = MUL_A_W'(ridge_r);
        mul_b = theta_r;
      end
      ST_E_DEN2: begin
        y_nxt   = DEN_W'(mul_r[42:16]) + DEN_W'(65536);
        idx_nxt = '0;
      end
      ST_E_GET: begin
        if (pass_r == '0) begin
          strobe_nxt = 1'b1;
          proj_nxt   = orig_q;
          last_nxt   = emit_last;
          idx_nxt    = idx_r + 1'b1;
        end else if (c_mag > ELEM_W'(theta_r)) begin
          acc_nxt = WIDE_W'({c_mag - ELEM_W'(theta_r), 16'b0});
          cnt_nxt = OUT_LAST_BIT;
          qo_nxt  = '0;
          neg_nxt = orig_q[ELEM_W-1];
        end else begin
          strobe_nxt = 1'b1;
          proj_nxt   = '0;
          last_nxt   = emit_last;
          idx_nxt    = idx_r + 1'b1;
        end
      end
      ST_E_DIV: begin
        if (ge) acc_nxt = diff[WIDE_W-1:0];
        qo_nxt  = q_fin;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          strobe_nxt = 1'b1;
          proj_nxt   = neg_r ? (~q_fin + 1'b1) : q_fin;
          last_nxt   = emit_last;
          idx_nxt    = idx_r + 1'b1;
        end
      end
      default: ;
    endcase

    if (pass_init) begin
      before_nxt = k_r;
      idx_nxt    = '0;
      wr_nxt     = '0;
      sum_nxt    = '0;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      loaded_r <= '0;
      radius_r <= RADIUS_RST;
      ridge_r  <= RIDGE_RST;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
      radius_r <= radius_nxt;
      ridge_r  <= ridge_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mstep_r  <= mstep_nxt;
    n_r      <= n_nxt;
    idx_r    <= idx_nxt;
    wr_r     <= wr_nxt;
    before_r <= before_nxt;
    k_r      <= k_nxt;
    pass_r   <= pass_nxt;
    init_r   <= init_nxt;
    theta_r  <= theta_nxt;
    sum_r    <= sum_nxt;
    m_r      <= m_nxt;
    keep_r   <= keep_nxt;
    mul_r    <= mul_p;
    b_r      <= b_nxt;
    a_r      <= a_nxt;
    d_r      <= d_nxt;
    disc_r   <= disc_nxt;
    acc_r    <= acc_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    cnt_r    <= cnt_nxt;
    qo_r     <= qo_nxt;
    neg_r    <= neg_nxt;
    proj_r   <= proj_nxt;
    last_r   <= last_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_projected = proj_r;
  assign out_threshold = theta_r;
  assign out_passes    = PASS_W'(pass_r);
  assign out_last_out  = last_r;

endmodule

// ----- rtl/core/enbp_chk.sv -----
// Port-level checker for the elastic-net ball projection top level.
// Depends on enbp_pkg; bound to elastic_net_ball_projection_top below.
module enbp_chk import enbp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_strobe,
  input logic [MAG_W-1:0]  out_threshold,
  input logic [PASS_W-1:0] out_passes,
  input logic              out_last_out
);

  // reset leaves the block idle and silent
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("not idle after reset");

  // only the final word of a vector can appear once busy has dropped
  a_mid_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_out |-> busy)
    else $error("result word while idle");

  // the final word is followed by a quiet cycle
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_out |=> !out_strobe)
    else $error("word after final word");

  // busy drops only together with the final word
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_strobe && out_last_out)
    else $error("busy fell without final word");

  // no refinement pass means no threshold
  a_pass_theta: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_passes == '0 |-> out_threshold == '0)
    else $error("threshold without a pass");

endmodule

bind elastic_net_ball_projection_top enbp_chk u_enbp_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_threshold (out_threshold),
  .out_passes    (out_passes),
  .out_last_out  (out_last_out)
);
